// ----- hdl/mfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Multipart frame parser package
// Shared constants for the multipart frame parser: event and message type
// codes, the special bytes of the framing, and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

	localparam int MAX_PARTS_DEF = 8;
	localparam int LEN_BITS_DEF  = 16;

	localparam int PART_IDX_W = 3;
	localparam int PART_LEN_W = 16;
	localparam int COUNT_W    = 4;
	localparam int BYTES_W    = 20;
	localparam int POS_W      = 4;
	localparam int NUM_KW     = 4;

	localparam logic [1:0] EV_PART  = 2'd0;
	localparam logic [1:0] EV_MSG   = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	localparam logic [2:0] MT_UNKNOWN   = 3'd0;
	localparam logic [2:0] MT_KEEPALIVE = 3'd1;
	localparam logic [2:0] MT_REQUEST   = 3'd2;
	localparam logic [2:0] MT_RESPONSE  = 3'd3;
	localparam logic [2:0] MT_PUBLISH   = 3'd4;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
	localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

	// Keyword text is right aligned, so the first character sits highest.
	localparam logic [NUM_KW-1:0][71:0] KW_TEXT = '{
		0: "keepalive",
		1: "request",
		2: "response",
		3: "publish"
	};

	localparam logic [NUM_KW-1:0][POS_W-1:0] KW_LEN = '{
		0: 4'd9,
		1: 4'd7,
		2: 4'd8,
		3: 4'd7
	};

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [POS_W-1:0] pos);
		logic [71:0]      s;
		logic [POS_W-1:0] n;
		logic [POS_W-1:0] off;
		begin
			s   = KW_TEXT[k];
			n   = KW_LEN[k];
			off = n - pos - 4'd1;
			if (pos < n) begin
				kw_char = s[8*off +: 8];
			end else begin
				kw_char = 8'd0;
			end
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/multipart_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Multipart frame parser
// Splits a byte stream into length-prefixed parts and messages, reports each
// finished part, each finished non-empty message with its type, and framing errors.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  data_byte
// result    out        out_valid/out_stall event_kind, part_index, part_length,
//                                          msg_type, part_count, msg_length
//
// One byte is taken per cycle unless in_stall is high; a result passes the input register, then the result register.
// The per-byte parse sits between the input register and the result register.
// Reset clears the parser state and the valid bits of both registers at once; their data is not reset.
// A stalled result holds the input register; a byte is still taken only while that register is empty.
//
`default_nettype none

module multipart_frame_parser
	import mfp_pkg::*;
#(
	parameter int MAX_PARTS = MAX_PARTS_DEF,
	parameter int LEN_BITS  = LEN_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 event_kind,
	output logic [PART_IDX_W-1:0]      part_index,
	output logic [PART_LEN_W-1:0]      part_length,
	output logic [2:0]                 msg_type,
	output logic [COUNT_W-1:0]         part_count,
	output logic [BYTES_W-1:0]         msg_length
);

	typedef enum logic [2:0] {
		PH_HDR_START,
		PH_HDR_DIGITS,
		PH_HDR_LF,
		PH_PAYLOAD,
		PH_TRAIL_CR,
		PH_TRAIL_LF,
		PH_TERM_LF,
		PH_RESYNC
	} phase_t;

	localparam logic [COUNT_W-1:0] PARTS_LIMIT = COUNT_W'(MAX_PARTS);

	phase_t                phase_q, phase_n;
	logic [LEN_BITS-1:0]   acc_q, acc_n;
	logic [LEN_BITS-1:0]   remain_q, remain_n;
	logic [COUNT_W-1:0]    parts_q, parts_n;
	logic [BYTES_W-1:0]    bytes_q, bytes_n;
	logic [NUM_KW-1:0]     flags_q, flags_n;
	logic [POS_W-1:0]      pos_q, pos_n;

	logic                  byte_valid_s1;
	logic [7:0]            byte_s1;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [PART_IDX_W-1:0] idx_q;
	logic [PART_LEN_W-1:0] plen_q;
	logic [2:0]            type_q;
	logic [COUNT_W-1:0]    count_q;
	logic [BYTES_W-1:0]    mlen_q;

	logic                  advance;
	logic                  proc;
	logic                  res_valid;
	logic [1:0]            res_kind;
	logic [PART_IDX_W-1:0] res_idx;
	logic [PART_LEN_W-1:0] res_plen;
	logic [2:0]            res_type;
	logic [COUNT_W-1:0]    res_count;
	logic [BYTES_W-1:0]    res_mlen;

	logic                  digit;
	logic                  err;
	logic [LEN_BITS+3:0]   acc_x10;
	logic [BYTES_W-1:0]    bytes_inc;
	logic [2:0]            cls;
	logic [POS_W-1:0]      pos_adv;

	assign advance  = !out_valid_q || !out_stall;
	assign proc     = byte_valid_s1 && advance;
	assign in_stall = byte_valid_s1 && !advance;

	always_comb begin
		cls = MT_UNKNOWN;
		if (flags_q[0]) cls = MT_KEEPALIVE;
		if (flags_q[1]) cls = MT_REQUEST;
		if (flags_q[2]) cls = MT_RESPONSE;
		if (flags_q[3]) cls = MT_PUBLISH;
	end

	always_comb begin
		digit     = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		acc_x10   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
			+ (LEN_BITS+4)'(byte_s1 - CH_ZERO);
		bytes_inc = (bytes_q < BYTES_MAX) ? bytes_q + 1'b1 : bytes_q;
		pos_adv   = pos_q;
		err       = 1'b0;

		phase_n   = phase_q;
		acc_n     = acc_q;
		remain_n  = remain_q;
		parts_n   = parts_q;
		bytes_n   = bytes_inc;
		flags_n   = flags_q;
		pos_n     = pos_q;

		res_valid = 1'b0;
		res_kind  = EV_PART;
		res_idx   = '0;
		res_plen  = '0;
		res_type  = MT_UNKNOWN;
		res_count = '0;
		res_mlen  = '0;

		case (phase_q)
			PH_RESYNC: begin
				bytes_n = bytes_q;
				if (byte_s1 == CH_LF) phase_n = PH_HDR_START;
			end
			PH_HDR_START: begin
				if (digit) begin
					if (parts_q >= PARTS_LIMIT) begin
						err = 1'b1;
					end else begin
						acc_n   = LEN_BITS'(byte_s1 - CH_ZERO);
						phase_n = PH_HDR_DIGITS;
					end
				end else if (byte_s1 == CH_CR) begin
					phase_n = PH_TERM_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_HDR_DIGITS: begin
				if (digit) begin
					if (acc_x10[LEN_BITS+3:LEN_BITS] != 4'd0) err = 1'b1;
					else acc_n = acc_x10[LEN_BITS-1:0];
				end else if (byte_s1 == CH_CR) begin
					phase_n = PH_HDR_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_HDR_LF: begin
				if (byte_s1 == CH_LF) begin
					remain_n = acc_q;
					if (acc_q == '0) begin
						if (parts_q == '0) begin
							for (int k = 0; k < NUM_KW; k++) begin
								if (KW_LEN[k] > pos_q) flags_n[k] = 1'b0;
							end
						end
						phase_n = PH_TRAIL_CR;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else begin
					err = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (parts_q == '0 && pos_q < POS_MAX) begin
					for (int k = 0; k < NUM_KW; k++) begin
						if (pos_q < KW_LEN[k] && byte_s1 != kw_char(2'(k), pos_q)) begin
							flags_n[k] = 1'b0;
						end
					end
					pos_adv = pos_q + 1'b1;
				end
				pos_n    = pos_adv;
				remain_n = remain_q - 1'b1;
				if (remain_q == LEN_BITS'(1)) begin
					if (parts_q == '0) begin
						for (int k = 0; k < NUM_KW; k++) begin
							if (KW_LEN[k] > pos_adv) flags_n[k] = 1'b0;
						end
					end
					phase_n = PH_TRAIL_CR;
				end
			end
			PH_TRAIL_CR: begin
				if (byte_s1 == CH_CR) phase_n = PH_TRAIL_LF;
				else err = 1'b1;
			end
			PH_TRAIL_LF: begin
				if (byte_s1 == CH_LF) begin
					res_valid = 1'b1;
					res_kind  = EV_PART;
					res_idx   = parts_q[PART_IDX_W-1:0];
					res_plen  = PART_LEN_W'(acc_q);
					parts_n   = parts_q + 1'b1;
					phase_n   = PH_HDR_START;
				end else begin
					err = 1'b1;
				end
			end
			PH_TERM_LF: begin
				if (byte_s1 == CH_LF) begin
					phase_n = PH_HDR_START;
					if (parts_q != '0) begin
						res_valid = 1'b1;
						res_kind  = EV_MSG;
						res_type  = cls;
						res_count = parts_q;
						res_mlen  = bytes_inc;
					end
					acc_n    = '0;
					remain_n = '0;
					parts_n  = '0;
					bytes_n  = '0;
					flags_n  = '1;
					pos_n    = '0;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				phase_n = PH_HDR_START;
			end
		endcase

		if (err) begin
			res_valid = 1'b1;
			res_kind  = EV_ERROR;
			res_idx   = parts_q[PART_IDX_W-1:0];
			res_plen  = '0;
			res_type  = MT_UNKNOWN;
			res_count = parts_q;
			res_mlen  = bytes_inc;
			acc_n     = '0;
			remain_n  = '0;
			parts_n   = '0;
			bytes_n   = '0;
			flags_n   = '1;
			pos_n     = '0;
			phase_n   = (byte_s1 == CH_LF) ? PH_HDR_START : PH_RESYNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR_START;
			acc_q         <= '0;
			remain_q      <= '0;
			parts_q       <= '0;
			bytes_q       <= '0;
			flags_q       <= '1;
			pos_q         <= '0;
			byte_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (!byte_valid_s1 || advance) begin
				byte_valid_s1 <= in_valid;
			end
			if (proc) begin
				phase_q  <= phase_n;
				acc_q    <= acc_n;
				remain_q <= remain_n;
				parts_q  <= parts_n;
				bytes_q  <= bytes_n;
				flags_q  <= flags_n;
				pos_q    <= pos_n;
			end
			if (advance) begin
				out_valid_q <= proc && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
		if (proc && res_valid) begin
			kind_q  <= res_kind;
			idx_q   <= res_idx;
			plen_q  <= res_plen;
			type_q  <= res_type;
			count_q <= res_count;
			mlen_q  <= res_mlen;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign part_index  = idx_q;
	assign part_length = plen_q;
	assign msg_type    = type_q;
	assign part_count  = count_q;
	assign msg_length  = mlen_q;

	a_parts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		parts_q <= PARTS_LIMIT)
		else $error("part counter exceeds its limit");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid_s1 && !advance |=> byte_valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte under stall");

	a_msg_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_MSG |-> part_count != '0)
		else $error("message result with no parts");

	a_part_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_PART |->
			msg_type == MT_UNKNOWN && part_count == '0 && msg_length == '0)
		else $error("part result carries message fields");

endmodule

`default_nettype wire

// ----- tb/mfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart frame parser checker
// Watches the byte and result channels of the parser, runs its own byte-level
// deframer on every accepted byte, queues the events that it predicts, and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module mfp_checker
	import mfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [1:0]           event_kind,
	input  wire logic [PART_IDX_W-1:0] part_index,
	input  wire logic [PART_LEN_W-1:0] part_length,
	input  wire logic [2:0]           msg_type,
	input  wire logic [COUNT_W-1:0]   part_count,
	input  wire logic [BYTES_W-1:0]   msg_length,
	output int                        fail_count,
	output int                        pending_count,
	output int                        part_events,
	output int                        msg_events,
	output int                        error_events
);

	localparam int LEN_MAX = (1 << LEN_BITS_DEF) - 1;

	typedef enum logic [2:0] {
		HDR_START, HDR_DIGITS, HDR_LF, PAYLOAD, TRAIL_CR, TRAIL_LF, TERM_LF, RESYNC
	} parse_state_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [PART_IDX_W-1:0] idx;
		logic [PART_LEN_W-1:0] plen;
		logic [2:0]            mtype;
		logic [COUNT_W-1:0]    count;
		logic [BYTES_W-1:0]    mlen;
	} frame_event_t;

	parse_state_t state;
	int           hdr_value;
	int           remaining;
	int           parts_done;
	int           byte_total;
	logic [3:0]   kw_alive;
	int           prefix_pos;
	frame_event_t expected_events[$];

	function automatic string keyword_text(input int k);
		case (k)
		0: return "keepalive";
		1: return "request";
		2: return "response";
		default: return "publish";
		endcase
	endfunction

	function automatic void drop_short_keywords();
		string kw;
		for (int k = 0; k < NUM_KW; k++) begin
			kw = keyword_text(k);
			if (kw.len() > prefix_pos) kw_alive[k] = 1'b0;
		end
	endfunction

	task automatic restart_message();
		hdr_value  = 0;
		remaining  = 0;
		parts_done = 0;
		byte_total = 0;
		kw_alive   = 4'hF;
		prefix_pos = 0;
	endtask

	task automatic post_event(input logic [1:0] kind, input int idx, input int plen,
			input logic [2:0] mtype, input int count, input int mlen);
		frame_event_t ev;
		ev       = '0;
		ev.kind  = kind;
		ev.idx   = idx[PART_IDX_W-1:0];
		ev.plen  = plen[PART_LEN_W-1:0];
		ev.mtype = mtype;
		ev.count = count[COUNT_W-1:0];
		ev.mlen  = mlen[BYTES_W-1:0];
		expected_events.push_back(ev);
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic       is_digit;
		logic       fault;
		int         value;
		string      kw;
		logic [2:0] mtype;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		fault = 1'b0;
		if (state == RESYNC) begin
			if (b == CH_LF) state = HDR_START;
		end else begin
			if (byte_total < BYTES_MAX) byte_total++;
			case (state)
			HDR_START: begin
				if (is_digit) begin
					if (parts_done >= MAX_PARTS_DEF) begin
						fault = 1'b1;
					end else begin
						hdr_value = int'(b - CH_ZERO);
						state = HDR_DIGITS;
					end
				end else if (b == CH_CR) begin
					state = TERM_LF;
				end else begin
					fault = 1'b1;
				end
			end
			HDR_DIGITS: begin
				if (is_digit) begin
					value = hdr_value * 10 + int'(b - CH_ZERO);
					if (value > LEN_MAX) fault = 1'b1;
					else hdr_value = value;
				end else if (b == CH_CR) begin
					state = HDR_LF;
				end else begin
					fault = 1'b1;
				end
			end
			HDR_LF: begin
				if (b == CH_LF) begin
					remaining = hdr_value;
					if (hdr_value == 0) begin
						if (parts_done == 0) drop_short_keywords();
						state = TRAIL_CR;
					end else begin
						state = PAYLOAD;
					end
				end else begin
					fault = 1'b1;
				end
			end
			PAYLOAD: begin
				if (parts_done == 0 && prefix_pos < POS_MAX) begin
					for (int k = 0; k < NUM_KW; k++) begin
						kw = keyword_text(k);
						if (prefix_pos < kw.len() && b != kw[prefix_pos]) kw_alive[k] = 1'b0;
					end
					prefix_pos++;
				end
				remaining--;
				if (remaining == 0) begin
					if (parts_done == 0) drop_short_keywords();
					state = TRAIL_CR;
				end
			end
			TRAIL_CR: begin
				if (b == CH_CR) state = TRAIL_LF;
				else fault = 1'b1;
			end
			TRAIL_LF: begin
				if (b == CH_LF) begin
					post_event(EV_PART, parts_done, hdr_value, MT_UNKNOWN, 0, 0);
					parts_done++;
					state = HDR_START;
				end else begin
					fault = 1'b1;
				end
			end
			TERM_LF: begin
				if (b == CH_LF) begin
					state = HDR_START;
					if (parts_done != 0) begin
						mtype = MT_UNKNOWN;
						if (kw_alive[0]) mtype = MT_KEEPALIVE;
						if (kw_alive[1]) mtype = MT_REQUEST;
						if (kw_alive[2]) mtype = MT_RESPONSE;
						if (kw_alive[3]) mtype = MT_PUBLISH;
						post_event(EV_MSG, 0, 0, mtype, parts_done, byte_total);
					end
					restart_message();
				end else begin
					fault = 1'b1;
				end
			end
			default: state = HDR_START;
			endcase
			if (fault) begin
				post_event(EV_ERROR, parts_done, 0, MT_UNKNOWN, parts_done, byte_total);
				restart_message();
				state = (b == CH_LF) ? HDR_START : RESYNC;
			end
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_event_t want;
		if (!arst_n) begin
			state = HDR_START;
			restart_message();
			expected_events.delete();
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("Result transfer with nothing expected: event_kind %0d", event_kind);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					compare_field("event_kind", want.kind, event_kind);
					compare_field("part_index", want.idx, part_index);
					compare_field("part_length", want.plen, part_length);
					compare_field("msg_type", want.mtype, msg_type);
					compare_field("part_count", want.count, part_count);
					compare_field("msg_length", want.mlen, msg_length);
					case (want.kind)
					EV_PART: part_events++;
					EV_MSG: msg_events++;
					default: error_events++;
					endcase
				end
			end
			if (in_valid && !in_stall) parse_byte(data_byte);
			pending_count = expected_events.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart frame parser testbench
// Feeds the parser directed framing cases and then randomized multipart
// messages with noise and corruption under four pacing mixes; the checker
// beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------

module tb
	import mfp_pkg::*;
();

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = 8'd0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            event_kind;
	logic [PART_IDX_W-1:0] part_index;
	logic [PART_LEN_W-1:0] part_length;
	logic [2:0]            msg_type;
	logic [COUNT_W-1:0]    part_count;
	logic [BYTES_W-1:0]    msg_length;

	int fail_count;
	int pending_count;
	int part_events;
	int msg_events;
	int error_events;

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         bytes_sent = 0;
	string      crlf;
	logic [7:0] frame_bytes[$];

	multipart_frame_parser DUT (.*);

	mfp_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		#24_000_000;
		$display("Timeout with %0d results still expected", pending_count);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic string keyword_text(input int k);
		case (k)
		0: return "keepalive";
		1: return "request";
		2: return "response";
		default: return "publish";
		endcase
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
	endtask

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		while (frame_bytes.size() != 0) put_byte(frame_bytes.pop_front());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	task automatic build_message();
		int    n_parts;
		int    plen;
		int    pick;
		int    start;
		string kw;
		start = frame_bytes.size();
		if ($urandom_range(19) == 0)
			repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
		pick = $urandom_range(19);
		if (pick == 0) n_parts = 0;
		else if (pick == 1) n_parts = MAX_PARTS_DEF;
		else if (pick == 2) n_parts = MAX_PARTS_DEF + 1;
		else n_parts = $urandom_range(1, 4);
		for (int k = 0; k < n_parts; k++) begin
			plen = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			kw = "";
			if (k == 0 && $urandom_range(3) != 0) begin
				kw = keyword_text($urandom_range(3));
				case ($urandom_range(3))
				0: plen = kw.len();
				1: plen = kw.len() + $urandom_range(1, 8);
				2: plen = $urandom_range(0, kw.len() - 1);
				default: ;
				endcase
			end
			if ($urandom_range(31) == 0) begin
				add_text($sformatf("%0d", $urandom_range(65536, 999999)));
			end else begin
				if ($urandom_range(15) == 0) add_text("00");
				add_text($sformatf("%0d", plen));
			end
			add_text(crlf);
			for (int j = 0; j < plen; j++) begin
				if (j < kw.len() && $urandom_range(15) != 0) frame_bytes.push_back(kw[j]);
				else frame_bytes.push_back(8'($urandom));
			end
			add_text(crlf);
		end
		add_text(crlf);
		if ($urandom_range(7) == 0)
			frame_bytes[$urandom_range(start, frame_bytes.size() - 1)] = 8'($urandom);
		else if ($urandom_range(15) == 0)
			frame_bytes.delete($urandom_range(start, frame_bytes.size() - 1));
	endtask

	initial begin
		int phase_start;
		crlf = "\015\012";
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_text(crlf);
		add_text({"9", crlf, "keepalive", crlf, crlf});
		add_text({"10", crlf, "request123", crlf, "0", crlf, crlf, crlf});
		add_text({"8", crlf, "response", crlf, crlf});
		add_text({"12", crlf, "publish/a/b/", crlf, crlf});
		add_text({"4", crlf, "keep", crlf, crlf});
		add_text({"0", crlf, crlf, crlf});
		add_text({"20", crlf, "keepalivekeepalive!!", crlf, crlf});
		add_text({"0007", crlf, "publisX", crlf, crlf});
		add_text({"4", crlf, crlf, crlf, crlf, crlf});
		repeat (MAX_PARTS_DEF) add_text({"1", crlf, "x", crlf});
		add_text(crlf);
		repeat (MAX_PARTS_DEF) add_text({"2", crlf, "yz", crlf});
		add_text({"1", crlf, "x", crlf, crlf});
		add_text({"1a", crlf});
		add_text("3\n");
		add_text({"x", crlf});
		add_text({"65536", crlf});
		add_text({"99999999", crlf});
		add_text({"3\015X", crlf});
		add_text({"3", crlf, "abcX", crlf});
		add_text({"3", crlf, "abc\015X", crlf});
		add_text({"1", crlf, "z", crlf, "\015X", crlf});
		add_text({"3", crlf, "abc\n"});
		add_text({"5", crlf, "hello", crlf, crlf});
		add_text("\n");
		add_text({"65535", "\015X", crlf});
		send_frame();
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 420) begin
				build_message();
				send_frame();
			end
			wait_drained();
		end

		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && pending_count != 0; i++) @(negedge clk);
		repeat (6) @(negedge clk);
		if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
		$display("Sent %0d bytes: directed framing cases, then random messages under four pacing mixes.",
			bytes_sent);
		$display("Checked %0d part, %0d message and %0d framing error results.",
			part_events, msg_events, error_events);
		if (fail_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/mfp_pkg.sv
hdl/multipart_frame_parser.sv
tb/mfp_checker.sv
tb/tb.sv
